// ===== design/biquad_shelf_filter_pcm16_macros.svh =====
// Assertion macros used by the biquad shelf filter controller (bqs_ctrl).
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef BIQUAD_SHELF_FILTER_PCM16_MACROS_SVH
`define BIQUAD_SHELF_FILTER_PCM16_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bqs_pkg.sv =====
// Shared types and constants for the biquad shelf filter.
// No dependencies; used by bqs_ctrl, bqs_datapath and the top level.
`default_nettype none

package bqs_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int ACC_W        = 52;
  localparam int NUM_MAC_TERMS = 5;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [2:0] {
    REG_B0         = 3'd0,
    REG_B1         = 3'd1,
    REG_B2         = 3'd2,
    REG_A1         = 3'd3,
    REG_A2         = 3'd4,
    REG_SCALE      = 3'd5,
    REG_CHAN_COUNT = 3'd6
  } cfg_reg_t;

  // Operand pair selected for the shared multiplier.
  typedef enum logic [2:0] {
    TERM_B0    = 3'd0,
    TERM_B1    = 3'd1,
    TERM_B2    = 3'd2,
    TERM_A1    = 3'd3,
    TERM_A2    = 3'd4,
    TERM_SCALE = 3'd5
  } term_t;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               end_of_block_out;
  } out_item_t;

  typedef struct packed {
    logic  load_in;
    logic  mul_en;
    term_t mul_sel;
    logic  acc_en;
    logic  acc_sub;
    logic  hist_wr;
    logic  out_load;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== design/bqs_ctrl.sv =====
// Sequencing controller for the biquad shelf filter.
// Depends on bqs_pkg and the assertion macro header.
`default_nettype none
`include "biquad_shelf_filter_pcm16_macros.svh"

module bqs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bqs_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SAT,
    S_SCALE,
    S_OUT
  } state_t;

  localparam logic [2:0] MAC_LAST = 3'(bqs_pkg::NUM_MAC_TERMS);

  state_t       state_r;
  logic [2:0]   cnt_r;
  logic         in_ready_r;
  logic         out_valid_r;
  bqs_pkg::term_t acc_term;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // The product register lags the operand select, so the
  // accumulator works on the term issued in the previous count.
  assign acc_term = bqs_pkg::term_t'(cnt_r - 3'd1);

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = bqs_pkg::TERM_B0;
    cmd.load_in  = (state_r == S_IDLE) && in_valid && in_ready_r;
    case (state_r)
      S_MAC: begin
        cmd.mul_en  = (cnt_r < MAC_LAST);
        cmd.mul_sel = bqs_pkg::term_t'(cnt_r);
        cmd.acc_en  = (cnt_r != 3'd0);
        cmd.acc_sub = acc_term inside {bqs_pkg::TERM_A1, bqs_pkg::TERM_A2};
      end
      S_SAT: begin
        cmd.hist_wr = 1'b1;
      end
      S_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bqs_pkg::TERM_SCALE;
      end
      S_OUT: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      default: begin
        cmd.mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.load_in) begin
            state_r    <= S_MAC;
            cnt_r      <= '0;
            in_ready_r <= 1'b0;
          end
        end
        S_MAC: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == MAC_LAST) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (cmd.out_load) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  `BQS_ASSERT_SAME(a_ready_only_idle, in_ready_r, state_r == S_IDLE, "in_ready outside idle")
  `BQS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready_r, !in_ready_r && state_r == S_MAC,
                   "accepted transaction did not start the MAC sequence")
  `BQS_ASSERT_SAME(a_cnt_range, state_r == S_MAC, cnt_r <= MAC_LAST, "MAC count out of range")
  `BQS_ASSERT_NEXT(a_out_load_sets_valid, cmd.out_load, out_valid_r && in_ready_r,
                   "output load did not raise out_valid and reopen input")

endmodule

`default_nettype wire

// ===== design/bqs_datapath.sv =====
// Datapath of the biquad shelf filter: configuration registers, per-channel
// history, shared multiplier, accumulator and output register. Depends on bqs_pkg.
`default_nettype none

module bqs_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bqs_pkg::dp_cmd_t   cmd,
  input  wire bqs_pkg::in_item_t  in_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output bqs_pkg::out_item_t      out_data
);

  localparam int CH_W  = bqs_pkg::CH_W;
  localparam int CNT_W = bqs_pkg::CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(bqs_pkg::MAX_CHANNELS);

  // Configuration
  logic signed [31:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [14:0]        scale_r;
  logic [3:0]         chan_count_r;

  // Per-channel history
  logic signed [15:0] xh1_r [bqs_pkg::MAX_CHANNELS];
  logic signed [15:0] xh2_r [bqs_pkg::MAX_CHANNELS];
  logic signed [31:0] yh1_r [bqs_pkg::MAX_CHANNELS];
  logic signed [31:0] yh2_r [bqs_pkg::MAX_CHANNELS];
  logic [CH_W-1:0]    pos_r;

  // Working registers
  logic signed [15:0] x_r;
  logic               eob_r;
  logic [CH_W-1:0]    ch_r;
  logic signed [31:0] y_r;
  logic signed [63:0] prod_r;
  bqs_pkg::acc_t      acc_r;
  bqs_pkg::out_item_t out_r;

  logic [CNT_W-1:0]   count_eff;
  logic [CH_W-1:0]    ch_cur;
  logic [CH_W-1:0]    ch_next;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  bqs_pkg::acc_t      term;
  bqs_pkg::acc_t      acc_sh;
  logic signed [31:0] y_sat;
  logic signed [63:0] q_wide;
  logic signed [15:0] q_sat;

  assign out_data = out_r;

  // A zero count behaves as one channel, a count above the history depth as full depth.
  always_comb begin
    if (chan_count_r == 4'd0) begin
      count_eff = CNT_W'(1);
    end else if (CNT_W'(chan_count_r) > MAX_CNT) begin
      count_eff = MAX_CNT;
    end else begin
      count_eff = CNT_W'(chan_count_r);
    end
  end

  assign ch_cur  = ({1'b0, pos_r} >= count_eff) ? '0 : pos_r;
  assign ch_next = (({1'b0, ch_cur} + CNT_W'(1)) >= count_eff) ? '0 : ch_cur + CH_W'(1);

  always_comb begin
    case (cmd.mul_sel)
      bqs_pkg::TERM_B0: begin
        op_a = b0_r;
        op_b = 32'(x_r);
      end
      bqs_pkg::TERM_B1: begin
        op_a = b1_r;
        op_b = 32'(xh1_r[ch_r]);
      end
      bqs_pkg::TERM_B2: begin
        op_a = b2_r;
        op_b = 32'(xh2_r[ch_r]);
      end
      bqs_pkg::TERM_A1: begin
        op_a = a1_r;
        op_b = yh1_r[ch_r];
      end
      bqs_pkg::TERM_A2: begin
        op_a = a2_r;
        op_b = yh2_r[ch_r];
      end
      bqs_pkg::TERM_SCALE: begin
        op_a = y_r;
        op_b = {17'd0, scale_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Feedback products are floored back to Q.30 before they are subtracted.
  assign term = cmd.acc_sub ? bqs_pkg::acc_t'(prod_r >>> 15) : bqs_pkg::acc_t'(prod_r);

  assign acc_sh = acc_r >>> 15;
  always_comb begin
    if ((acc_sh[bqs_pkg::ACC_W-1:31] == '0) || (acc_sh[bqs_pkg::ACC_W-1:31] == '1)) begin
      y_sat = acc_sh[31:0];
    end else if (acc_sh[bqs_pkg::ACC_W-1]) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = 32'sh7fff_ffff;
    end
  end

  // Truncation toward zero: bias negative products before the arithmetic shift.
  assign q_wide = (prod_r + (prod_r[63] ? 64'sd1073741823 : 64'sd0)) >>> 30;
  always_comb begin
    if ((q_wide[63:15] == '0) || (q_wide[63:15] == '1)) begin
      q_sat = q_wide[15:0];
    end else if (q_wide[63]) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r         <= 32'sh4000_0000;
      b1_r         <= '0;
      b2_r         <= '0;
      a1_r         <= '0;
      a2_r         <= '0;
      scale_r      <= 15'd29491;
      chan_count_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        bqs_pkg::REG_B0:         b0_r         <= cfg_data;
        bqs_pkg::REG_B1:         b1_r         <= cfg_data;
        bqs_pkg::REG_B2:         b2_r         <= cfg_data;
        bqs_pkg::REG_A1:         a1_r         <= cfg_data;
        bqs_pkg::REG_A2:         a2_r         <= cfg_data;
        bqs_pkg::REG_SCALE:      scale_r      <= cfg_data[14:0];
        bqs_pkg::REG_CHAN_COUNT: chan_count_r <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < bqs_pkg::MAX_CHANNELS; i++) begin
        xh1_r[i] <= '0;
        xh2_r[i] <= '0;
        yh1_r[i] <= '0;
        yh2_r[i] <= '0;
      end
    end else begin
      if (cmd.load_in) begin
        pos_r <= ch_next;
      end
      if (cmd.hist_wr) begin
        xh2_r[ch_r] <= xh1_r[ch_r];
        xh1_r[ch_r] <= x_r;
        yh2_r[ch_r] <= yh1_r[ch_r];
        yh1_r[ch_r] <= y_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r   <= in_data.sample_in;
      eob_r <= in_data.end_of_block;
      ch_r  <= ch_cur;
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= cmd.acc_sub ? acc_r - term : acc_r + term;
    end
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.hist_wr) begin
      y_r <= y_sat;
    end
    if (cmd.out_load) begin
      out_r.sample_out       <= q_sat;
      out_r.end_of_block_out <= eob_r;
    end
  end

endmodule

`default_nettype wire

// ===== design/biquad_shelf_filter_pcm16.sv =====
// Per-channel direct form I biquad with output gain for interleaved 16-bit PCM.
// Transactions enter on in_valid/in_ready with an in_item_t payload (sample and
// end-of-block mark) and leave on out_valid/out_ready as an out_item_t.
// Channels are interleaved; each sample uses the history of its own channel and
// the channel position wraps at channel_count (zero acts as one, more than 8 as 8).
// Coefficients, output scale and channel count are written through the cfg port
// (index 0..6: b0, b1, b2, a1, a2, output_scale, channel_count); cfg_ready is
// always high and writes to other indexes are dropped. Write only while idle.
// From acceptance to the output register loading, an item goes through the
// MAC steps on one shared 32x32 multiplier and accumulator for the five filter
// terms, a step to saturate and update history, a step for the scale multiply
// and a step to round and load. out_valid rises with the output register load.
// The block works on one transaction at a time; in_ready returns when the
// result is loaded, so no new sample is taken before the last one is through,
// and the next sample can be taken while the result waits.
// If the receiver stalls, the finished item waits in the output register and
// the next item stalls in its final step until that register is free.
// Synchronous active-low reset restores the register defaults, clears all
// history and the channel position, and drops any pending output.
// Depends on bqs_pkg, bqs_ctrl and bqs_datapath.
`default_nettype none

module biquad_shelf_filter_pcm16 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bqs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bqs_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  bqs_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  bqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bqs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/biquad_shelf_filter_pcm16_tb.sv =====
// Self-checking testbench for the per-channel biquad with output gain.
// A directed table, then randomized filter settings and sample streams; needs bqs_pkg and
// the biquad_shelf_filter_pcm16 RTL.
`timescale 1ns / 100ps

module biquad_shelf_filter_pcm16_tb;

  localparam logic [2:0] REG_NONE = 3'd7;  // not a register; writes are dropped
  localparam int NUM_DIR = 39;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 50;
  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;
  localparam longint A2_LIM = 64'sd912680550;  // 0.85 in Q2.30

  typedef enum logic { ROW_PCM, ROW_REG } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [31:0]        data;
    logic signed [15:0] pcm;
    logic               eob;
    logic               known;
    logic signed [15:0] gold;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bqs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bqs_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // Shadow of the filter settings and per-channel history.
  longint      coef_b0 = 64'sd1073741824;
  longint      coef_b1 = 0;
  longint      coef_b2 = 0;
  longint      coef_a1 = 0;
  longint      coef_a2 = 0;
  longint      gain_q15 = 29491;
  int unsigned chan_count = 1;
  int unsigned chan_pos = 0;
  longint      hist_x1 [bqs_pkg::MAX_CHANNELS] = '{default: 0};
  longint      hist_x2 [bqs_pkg::MAX_CHANNELS] = '{default: 0};
  longint      hist_y1 [bqs_pkg::MAX_CHANNELS] = '{default: 0};
  longint      hist_y2 [bqs_pkg::MAX_CHANNELS] = '{default: 0};

  bqs_pkg::out_item_t pending_pcm [$];
  int          err_cnt = 0;
  bit          no_idle = 1'b0;
  longint      walk = 0;
  dir_row_t    dir_tab [NUM_DIR];

  biquad_shelf_filter_pcm16 u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 25);
  end

  function automatic void shadow_write(logic [2:0] idx, logic [31:0] data);
    case (idx)
      bqs_pkg::REG_B0:         coef_b0 = longint'($signed(data));
      bqs_pkg::REG_B1:         coef_b1 = longint'($signed(data));
      bqs_pkg::REG_B2:         coef_b2 = longint'($signed(data));
      bqs_pkg::REG_A1:         coef_a1 = longint'($signed(data));
      bqs_pkg::REG_A2:         coef_a2 = longint'($signed(data));
      bqs_pkg::REG_SCALE:      gain_q15 = longint'(data[14:0]);
      bqs_pkg::REG_CHAN_COUNT: chan_count = data[3:0];
      default:                 ;
    endcase
  endfunction

  // Runs one sample through the shadow filter and returns the output it should give.
  function automatic bqs_pkg::out_item_t filter_step(bqs_pkg::in_item_t it);
    int unsigned        cnt;
    int unsigned        ch;
    longint             x;
    longint             acc;
    longint             y;
    longint             prod;
    longint             q;
    bqs_pkg::out_item_t r;
    cnt = (chan_count == 0) ? 1 : chan_count;
    if (cnt > bqs_pkg::MAX_CHANNELS) cnt = bqs_pkg::MAX_CHANNELS;
    if (chan_pos >= cnt) chan_pos = 0;
    ch = chan_pos;
    x = longint'($signed(it.sample_in));
    // Feedback products drop to Q.30 with a floor shift before they are summed.
    acc = coef_b0 * x + coef_b1 * hist_x1[ch] + coef_b2 * hist_x2[ch]
        - ((coef_a1 * hist_y1[ch]) >>> 15) - ((coef_a2 * hist_y2[ch]) >>> 15);
    y = acc >>> 15;
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    hist_x2[ch] = hist_x1[ch];
    hist_x1[ch] = x;
    hist_y2[ch] = hist_y1[ch];
    hist_y1[ch] = y;
    prod = y * gain_q15;
    q = (prod >= 0) ? (prod >>> 30) : -((-prod) >>> 30);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    chan_pos = (ch + 1 >= cnt) ? 0 : ch + 1;
    r.sample_out = q[15:0];
    r.end_of_block_out = it.end_of_block;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, data);
  endtask

  // Stops the sample stream and waits until every queued output has come back.
  task automatic drain_filter();
    in_valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
  endtask

  task automatic send_pcm(bqs_pkg::in_item_t it, bit known, logic signed [15:0] gold);
    bqs_pkg::out_item_t want;
    if (!no_idle && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    want = filter_step(it);
    if (known) want.sample_out = gold;
    pending_pcm.push_back(want);
  endtask

  function automatic logic signed [15:0] rand_pcm();
    logic signed [15:0] s;
    case ($urandom_range(9))
      0, 1, 2, 3: s = $urandom;
      4, 5:       s = $urandom_range(0, 511) - 256;
      6: begin
        case ($urandom_range(4))
          0:       s = 16'sh8000;
          1:       s = 16'sh7FFF;
          2:       s = 16'sd0;
          3:       s = 16'sd1;
          default: s = -16'sd1;
        endcase
      end
      default: begin
        // Random walk, closer to real audio than white noise.
        walk = walk + $urandom_range(0, 4096) - 2048;
        if (walk > 32767) walk = 32767;
        if (walk < -32768) walk = -32768;
        s = walk[15:0];
      end
    endcase
    return s;
  endfunction

  always @(posedge clk) begin
    bqs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pcm.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected output transaction: sample %0d eob %0b",
                   $signed(out_data.sample_out), out_data.end_of_block_out);
      end else begin
        want = pending_pcm.pop_front();
        if (out_data.sample_out !== want.sample_out ||
            out_data.end_of_block_out !== want.end_of_block_out) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("output mismatch at %0t: expected sample %0d eob %0b, got sample %0d eob %0b",
                     $realtime, $signed(want.sample_out), want.end_of_block_out,
                     $signed(out_data.sample_out), out_data.end_of_block_out);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [31:0]        corners [5];
    logic [31:0]        r;
    logic [31:0]        coefs [5];
    bqs_pkg::in_item_t  it;
    bit                 in_cfg;
    int                 mode;
    longint             a2v;
    longint             a1v;
    longint             bnd;

    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h4000_0000, 32'hC000_0000};
    dir_tab = '{
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd0,      1'b0, 1'b1, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh7FFF,   1'b1, 1'b1, 16'sd29490},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh8000,   1'b0, 1'b1, -16'sd29491},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, -16'sd1,     1'b0, 1'b1, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd2,      1'b1, 1'b1, 16'sd1},
      '{ROW_REG, bqs_pkg::REG_B0,         32'h7FFF_FFFF, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_SCALE,      32'h0000_7FFF, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_CHAN_COUNT, 32'h0000_0003, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh7FFF,   1'b0, 1'b1, 16'sh7FFF},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh8000,   1'b1, 1'b1, 16'sh8000},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd0,      1'b0, 1'b1, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_B0,         32'h8000_0000, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh8000,   1'b0, 1'b1, 16'sh7FFF},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh7FFF,   1'b0, 1'b1, 16'sh8000},
      '{ROW_REG, bqs_pkg::REG_SCALE,      32'hFFFF_8000, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh7FFF,   1'b1, 1'b1, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_B0,         32'h4000_0000, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_B1,         32'h2000_0000, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_B2,         32'hE000_0000, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_A1,         32'hC000_0000, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_A2,         32'h1000_0000, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_SCALE,      32'h0000_7FFF, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_CHAN_COUNT, 32'hFFFF_FFF0, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd1000,   1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, -16'sd2000,  1'b1, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd30000,  1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, -16'sd30000, 1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_CHAN_COUNT, 32'h0000_000F, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd12345,  1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh8000,   1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh7FFF,   1'b1, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, -16'sd7,     1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd500,    1'b0, 1'b0, 16'sd0},
      '{ROW_REG, bqs_pkg::REG_CHAN_COUNT, 32'h0000_0002, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_REG, REG_NONE,                32'hFFFF_FFFF, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh7FFF,   1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh7FFF,   1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sh8000,   1'b0, 1'b0, 16'sd0},
      '{ROW_PCM, REG_NONE,                32'h0000_0000, 16'sd100,    1'b1, 1'b0, 16'sd0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: register rows are applied only once the pipeline is empty.
    in_cfg = 1'b0;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_tab[i].kind == ROW_REG) begin
        if (!in_cfg) begin
          drain_filter();
          in_cfg = 1'b1;
        end
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        it.sample_in = dir_tab[i].pcm;
        it.end_of_block = dir_tab[i].eob;
        send_pcm(it, dir_tab[i].known, dir_tab[i].gold);
      end
    end

    // Random phases, each with a fresh filter setting written while idle.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_filter();
      no_idle = (p == 2);
      mode = (p == 0) ? 2 : $urandom_range(3);
      if (mode == 2) begin
        for (int k = 0; k < 5; k++) coefs[k] = corners[$urandom_range(4)];
      end else if (mode == 3) begin
        for (int k = 0; k < 5; k++) coefs[k] = $urandom;
      end else begin
        // Stable design: poles kept inside the unit circle.
        a2v = longint'($urandom_range(0, 32'(2 * A2_LIM))) - A2_LIM;
        bnd = (64'sd1073741824 + a2v) * 95 / 100;
        a1v = longint'($urandom_range(0, 32'(2 * bnd))) - bnd;
        for (int k = 0; k < 3; k++) coefs[k] = $signed($urandom) >>> 2;
        coefs[3] = a1v[31:0];
        coefs[4] = a2v[31:0];
      end
      write_reg(bqs_pkg::REG_B0, coefs[0]);
      write_reg(bqs_pkg::REG_B1, coefs[1]);
      write_reg(bqs_pkg::REG_B2, coefs[2]);
      write_reg(bqs_pkg::REG_A1, coefs[3]);
      write_reg(bqs_pkg::REG_A2, coefs[4]);
      r = $urandom;
      if (mode == 2) begin
        case ($urandom_range(2))
          0:       r[14:0] = 15'd0;
          1:       r[14:0] = 15'h7FFF;
          default: r[14:0] = 15'd1;
        endcase
      end
      write_reg(bqs_pkg::REG_SCALE, r);
      r = $urandom;
      if ($urandom_range(3) != 0) r[3:0] = $urandom_range(1, bqs_pkg::MAX_CHANNELS);
      write_reg(bqs_pkg::REG_CHAN_COUNT, r);
      if ($urandom_range(2) == 0) write_reg(REG_NONE, $urandom);
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.sample_in = rand_pcm();
        it.end_of_block = ($urandom_range(7) == 0);
        send_pcm(it, 1'b0, 16'sd0);
      end
    end

    drain_filter();
    no_idle = 1'b0;
    repeat (24) @(posedge clk);
    if (err_cnt == 0 && pending_pcm.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
